### rtl/wrm_pkg.sv
package wrm_pkg;

  // default sizes
  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 12;

  // window length register
  localparam int             WL_W         = 7;
  localparam logic [WL_W-1:0] WINDOW_RESET = 7'd50;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIV,
    ST_ROOT,
    ST_OUT
  } wrm_state_t;

  // status of one serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } wrm_stat_t;

endpackage

### rtl/window_rms_min_max.sv
// channel  | direction | ports                           | word
// ---------+-----------+---------------------------------+--------------------------------
// in       | slave     | in_tvalid/in_tready/in_tdata    | sample
// out      | master    | out_tvalid/out_tready/out_tdata | rms_value, min_value, max_value,
//          |           |                                 | sample_total
// cfg      | write     | cfg_wr_en/cfg_wr_data           | window_length
//
// an ordinary sample passes the serial squarer, which adds one multiplier bit per cycle into
// the sum of squares
// the sample that closes a window also passes the serial divider and then the serial root,
// and its result is then loaded into the output register
// synchronous active-low reset; window length resets to 50, all accumulators to zero
// a result waiting on out_tready holds only a closing sample; other samples keep flowing
module window_rms_min_max #(
  parameter int SampleBits = wrm_pkg::SAMPLE_BITS_DEF,
  parameter int MaxWindow  = wrm_pkg::MAX_WINDOW_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // sample
  input  logic [((SampleBits+7)/8)*8-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // rms_value, min_value, max_value, sample_total, zero pad
  output logic [((3*SampleBits+$clog2(MaxWindow+1)+7)/8)*8-1:0] out_tdata,
  input  logic                     cfg_wr_en,
  input  logic [wrm_pkg::WL_W-1:0] cfg_wr_data
);
  import wrm_pkg::*;

  localparam int CNT_W  = $clog2(MaxWindow + 1);
  localparam int PROD_W = 2 * SampleBits;
  localparam int SUM_W  = PROD_W + $clog2(MaxWindow);
  localparam int OUT_W  = ((3 * SampleBits + CNT_W + 7) / 8) * 8;
  localparam int CMP_W  = (CNT_W > WL_W ? CNT_W : WL_W) + 1;

  wrm_state_t            state_r, state_nxt;
  logic [WL_W-1:0]       wlen_r;
  logic                  close_r, close_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]      out_tdata_r;

  logic                  accept;
  logic                  acc_start, acc_clear, div_start, sqrt_start, out_load;
  wrm_stat_t             acc_stat, div_stat, sqrt_stat;
  logic [CNT_W-1:0]      count;
  logic [SampleBits-1:0] min_value, max_value, rms_value;
  logic [SUM_W-1:0]      sum, quot;
  logic [CMP_W-1:0]      eff_len;

  // window length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      wlen_r <= cfg_wr_data;
    end
  end

  // effective length: zero acts as one, saturate at the window depth
  always_comb begin
    priority if (wlen_r == '0) begin
      eff_len = CMP_W'(1);
    end else if (CMP_W'(wlen_r) > CMP_W'(MaxWindow)) begin
      eff_len = CMP_W'(MaxWindow);
    end else begin
      eff_len = CMP_W'(wlen_r);
    end
  end

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign close_nxt = accept ? ((CMP_W'(count) + CMP_W'(1)) >= eff_len) : close_r;

  wrm_acc #(
    .SampleBits(SampleBits),
    .MaxWindow (MaxWindow)
  ) u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (acc_start),
    .clear    (acc_clear),
    .sample   (in_tdata[SampleBits-1:0]),
    .stat     (acc_stat),
    .count    (count),
    .min_value(min_value),
    .max_value(max_value),
    .sum      (sum)
  );

  wrm_div #(
    .NumW(SUM_W),
    .DenW(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (sum),
    .den  (count),
    .stat (div_stat),
    .quot (quot)
  );

  // the mean never exceeds the largest square, so its low bits carry it all
  wrm_sqrt #(
    .RootW(SampleBits)
  ) u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sqrt_start),
    .rad  (quot[PROD_W-1:0]),
    .stat (sqrt_stat),
    .root (rms_value)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      close_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      close_r      <= close_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // next state and unit starts
  always_comb begin
    state_nxt  = state_r;
    acc_start  = 1'b0;
    acc_clear  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          acc_start = 1'b1;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (acc_stat.done) begin
          if (close_r) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          sqrt_start = 1'b1;
          state_nxt  = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_stat.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          acc_clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    priority if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= OUT_W'({count, max_value, min_value, rms_value});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  // the window never holds more samples than the accumulator depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count) <= CMP_W'(MaxWindow))
    else $error("sample count beyond window depth");

  // the mean fits in the root's radicand
  a_mean_fits: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |-> (quot >> PROD_W) == '0)
    else $error("mean wider than radicand");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_tvalid_r || out_tready))
    else $error("result overwritten");

  // loaded result is consistent: min <= rms <= max
  a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (min_value <= rms_value) && (rms_value <= max_value))
    else $error("rms outside min/max");

  // only one serial unit runs at a time
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({acc_stat.busy, div_stat.busy, sqrt_stat.busy}) <= 1)
    else $error("serial units overlap");
`endif

endmodule

### rtl/wrm_acc.sv
module wrm_acc #(
  parameter int SampleBits = 12,
  parameter int MaxWindow  = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  clear,
  input  logic [SampleBits-1:0]                 sample,
  output wrm_pkg::wrm_stat_t                    stat,
  output logic [$clog2(MaxWindow+1)-1:0]        count,
  output logic [SampleBits-1:0]                 min_value,
  output logic [SampleBits-1:0]                 max_value,
  output logic [2*SampleBits+$clog2(MaxWindow)-1:0] sum
);
  import wrm_pkg::*;

  localparam int CNT_W  = $clog2(MaxWindow + 1);
  localparam int PROD_W = 2 * SampleBits;
  localparam int SUM_W  = PROD_W + $clog2(MaxWindow);
  localparam int BIT_W  = $clog2(SampleBits + 1);

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [SampleBits-1:0] min_r, min_nxt;
  logic [SampleBits-1:0] max_r, max_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [SampleBits-1:0] mplier_r, mplier_nxt;
  logic [PROD_W-1:0]     mcand_r, mcand_nxt;
  logic [BIT_W-1:0]      bits_r, bits_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  // fold sample into min/max/count, then square it one multiplier bit per cycle
  always_comb begin
    count_nxt  = count_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    sum_nxt    = sum_r;
    mplier_nxt = mplier_r;
    mcand_nxt  = mcand_r;
    bits_nxt   = bits_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    priority if (start) begin
      if (count_r == '0) begin
        min_nxt = sample;
        max_nxt = sample;
        sum_nxt = '0;
      end else begin
        if (sample < min_r) min_nxt = sample;
        if (sample > max_r) max_nxt = sample;
      end
      count_nxt  = count_r + CNT_W'(1);
      mplier_nxt = sample;
      mcand_nxt  = PROD_W'(sample);
      bits_nxt   = BIT_W'(SampleBits);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) sum_nxt = sum_r + SUM_W'(mcand_r);
      mplier_nxt = mplier_r >> 1;
      mcand_nxt  = mcand_r << 1;
      bits_nxt   = bits_r - BIT_W'(1);
      if (bits_r == BIT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      // window closed: restart the count
      if (clear) count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
      sum_r   <= '0;
      bits_r  <= '0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      sum_r   <= sum_nxt;
      bits_r  <= bits_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mplier_r <= mplier_nxt;
    mcand_r  <= mcand_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign count     = count_r;
  assign min_value = min_r;
  assign max_value = max_r;
  assign sum       = sum_r;

endmodule

### rtl/wrm_div.sv
module wrm_div #(
  parameter int NumW = 30,
  parameter int DenW = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NumW-1:0]    num,
  input  logic [DenW-1:0]    den,
  output wrm_pkg::wrm_stat_t stat,
  output logic [NumW-1:0]    quot
);
  import wrm_pkg::*;

  localparam int CNT_W = $clog2(NumW + 1);

  logic [NumW-1:0]  quot_r, quot_nxt;
  logic [DenW-1:0]  den_r, den_nxt;
  logic [DenW-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DenW:0]    rem_sh;
  logic             fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem_r, quot_r[NumW-1]};
    fits     = rem_sh >= {1'b0, den_r};
    quot_nxt = quot_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    priority if (start) begin
      quot_nxt = num;
      den_nxt  = den;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? DenW'(rem_sh - {1'b0, den_r}) : DenW'(rem_sh);
      quot_nxt = {quot_r[NumW-2:0], fits};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      // idle: everything holds
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;

endmodule

### rtl/wrm_sqrt.sv
module wrm_sqrt #(
  parameter int RootW = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2*RootW-1:0] rad,
  output wrm_pkg::wrm_stat_t stat,
  output logic [RootW-1:0]   root
);
  import wrm_pkg::*;

  localparam int RAD_W = 2 * RootW;
  localparam int REM_W = RootW + 2;
  localparam int CNT_W = $clog2(RootW + 1);

  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [RootW-1:0] root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             fits;

  // digit-by-digit floor root, two radicand bits and one root bit per cycle
  always_comb begin
    rem_sh   = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial    = (REM_W + 2)'({root_r, 2'b01});
    fits     = rem_sh >= trial;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    priority if (start) begin
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(RootW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_nxt = {root_r[RootW-2:0], fits};
      rad_nxt  = rad_r << 2;
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      // idle: everything holds
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule
